// File: hdl/stc_pkg.sv
package stc_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_OUT_W  = 10;
  localparam int SIZE_W     = 11;
  localparam int MAX_ROWS   = 1024;
  localparam int MIN_SIZE   = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0]     THRESHOLD_RESET = 16'd100;
  localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1024;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COLUMNS   = 2'd1,
    REG_ROWS      = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CLASS_FREE     = 2'd0,
    CLASS_OCCUPIED = 2'd1,
    CLASS_UNKNOWN  = 2'd2
  } cell_class_t;

  typedef struct packed {
    logic signed [15:0] elevation;
    logic               unknown;
    logic               frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]     cell_row;
    logic [COL_OUT_W-1:0] cell_column;
    logic [1:0]           cell_class;
    logic                 frame_last;
  } out_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]     cell_row;
    logic [COL_OUT_W-1:0] cell_column;
    logic                 frame_last;
  } cell_pos_t;

endpackage

// File: hdl/stc_cfg.sv
module stc_cfg #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [31:0]                       threshold_sq,
  output logic [$clog2(MAX_COLUMNS):0]      cols,
  output logic [stc_pkg::SIZE_W-1:0]        rows
);
  import stc_pkg::*;

  localparam int CXW = $clog2(MAX_COLUMNS) + 1;
  localparam int COL_RESET = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;

  logic [15:0]       threshold_r;
  logic [SIZE_W-1:0] cols_raw_r;
  logic [SIZE_W-1:0] rows_raw_r;
  logic [31:0]       threshold_sq_r;
  logic [CXW-1:0]    cols_r;
  logic [SIZE_W-1:0] rows_r;

  logic              wr_en;
  reg_index_t        wr_index;
  logic [SIZE_W-1:0] wsize;
  logic [CXW-1:0]    cols_nxt;
  logic [SIZE_W-1:0] rows_nxt;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_index = reg_index_t'(paddr[3:2]);
  assign wsize    = pwdata[SIZE_W-1:0];

  always_comb begin
    if (32'(wsize) < 32'(MIN_SIZE)) begin
      cols_nxt = CXW'(MIN_SIZE);
    end else if (32'(wsize) > 32'(MAX_COLUMNS)) begin
      cols_nxt = CXW'(MAX_COLUMNS);
    end else begin
      cols_nxt = CXW'(wsize);
    end
    if (32'(wsize) < 32'(MIN_SIZE)) begin
      rows_nxt = SIZE_W'(MIN_SIZE);
    end else if (32'(wsize) > 32'(MAX_ROWS)) begin
      rows_nxt = SIZE_W'(MAX_ROWS);
    end else begin
      rows_nxt = wsize;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RESET;
      threshold_sq_r <= 32'(THRESHOLD_RESET) * 32'(THRESHOLD_RESET);
      cols_raw_r     <= SIZE_RESET;
      rows_raw_r     <= SIZE_RESET;
      cols_r         <= CXW'(COL_RESET);
      rows_r         <= SIZE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_THRESHOLD: begin
          threshold_r    <= pwdata[15:0];
          threshold_sq_r <= 32'(pwdata[15:0]) * 32'(pwdata[15:0]);
        end
        REG_COLUMNS: begin
          cols_raw_r <= wsize;
          cols_r     <= cols_nxt;
        end
        REG_ROWS: begin
          rows_raw_r <= wsize;
          rows_r     <= rows_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (wr_index)
      REG_THRESHOLD: prdata = CFG_DATA_W'(threshold_r);
      REG_COLUMNS:   prdata = CFG_DATA_W'(cols_raw_r);
      REG_ROWS:      prdata = CFG_DATA_W'(rows_raw_r);
      default:       prdata = '0;
    endcase
  end

  assign threshold_sq = threshold_sq_r;
  assign cols         = cols_r;
  assign rows         = rows_r;

endmodule

// File: hdl/stc_row_buffer.sv
module stc_row_buffer #(
  parameter int MAX_COLUMNS = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stc_pkg::in_beat_t                 in_data,
  input  logic [$clog2(MAX_COLUMNS):0]      cols,
  input  logic [stc_pkg::SIZE_W-1:0]        rows,
  input  logic                              s1_take,
  output logic                              s1_valid,
  output stc_pkg::cell_pos_t                s1_pos,
  output logic [HEIGHT_BITS:0]              s1_cell,
  output logic [HEIGHT_BITS:0]              s1_sample,
  output logic [HEIGHT_BITS:0]              s1_ahead
);
  import stc_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CXW = CW + 1;
  localparam int EW  = (HEIGHT_BITS > 16) ? HEIGHT_BITS : 16;

  logic [HEIGHT_BITS:0] mem [MAX_COLUMNS];

  logic [CW-1:0]        col_cnt_r;
  logic [ROW_W-1:0]     row_cnt_r;
  logic [HEIGHT_BITS:0] rd_r;
  logic                 ahead_zero_r;
  logic                 v1_r;
  cell_pos_t            pos_r;
  logic [HEIGHT_BITS:0] cell_r;
  logic [HEIGHT_BITS:0] sample_r;

  logic                 en1;
  logic                 accept;
  logic [CW-1:0]        c_cur;
  logic [ROW_W-1:0]     r_cur;
  logic [CXW-1:0]       c_inc;
  logic [SIZE_W-1:0]    r_inc;
  logic [CXW-1:0]       c_ext;
  logic [ROW_W-1:0]     r_dec;
  logic                 col_wrap;
  logic [CW-1:0]        col_cnt_nxt;
  logic [ROW_W-1:0]     row_cnt_nxt;
  logic                 produce;
  logic                 last;
  logic [EW-1:0]        elev_ext;
  logic [HEIGHT_BITS:0] sample;
  logic [HEIGHT_BITS:0] ahead;
  cell_pos_t            pos;

  assign en1      = !v1_r || s1_take;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  assign c_cur = in_data.frame_start ? '0 : col_cnt_r;
  assign r_cur = in_data.frame_start ? '0 : row_cnt_r;
  assign c_ext = CXW'(c_cur);
  assign c_inc = c_ext + CXW'(1);
  assign r_inc = SIZE_W'(r_cur) + SIZE_W'(1);
  assign r_dec = r_cur - ROW_W'(1);

  assign col_wrap    = c_inc >= cols;
  assign col_cnt_nxt = col_wrap ? '0 : c_inc[CW-1:0];
  assign row_cnt_nxt = !col_wrap ? r_cur : ((r_inc >= rows) ? '0 : r_inc[ROW_W-1:0]);

  assign produce = (r_cur >= ROW_W'(2)) && (SIZE_W'(r_cur) <= rows - SIZE_W'(1))
                && (c_cur != '0) && (c_ext <= cols - CXW'(2));
  assign last    = (SIZE_W'(r_dec) == rows - SIZE_W'(2)) && (c_ext == cols - CXW'(2));

  assign elev_ext = EW'($unsigned(in_data.elevation));
  assign sample   = {in_data.unknown, elev_ext[HEIGHT_BITS-1:0]};
  assign ahead    = ahead_zero_r ? '0 : rd_r;

  assign pos.cell_row    = r_dec;
  assign pos.cell_column = COL_OUT_W'(c_cur);
  assign pos.frame_last  = last;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[c_cur] <= sample;
      rd_r       <= mem[c_inc[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      v1_r         <= 1'b0;
      ahead_zero_r <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_r    <= col_cnt_nxt;
        row_cnt_r    <= row_cnt_nxt;
        ahead_zero_r <= c_inc >= CXW'(MAX_COLUMNS);
      end
      if (en1) begin
        v1_r <= accept && produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r   <= ahead;
      sample_r <= sample;
      pos_r    <= pos;
    end
  end

  assign s1_valid  = v1_r;
  assign s1_pos    = pos_r;
  assign s1_cell   = cell_r;
  assign s1_sample = sample_r;
  assign s1_ahead  = ahead;

endmodule

// File: hdl/stc_grade.sv
module stc_grade #(
  parameter int HEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  stc_pkg::cell_pos_t   s1_pos,
  input  logic [HEIGHT_BITS:0] s1_cell,
  input  logic [HEIGHT_BITS:0] s1_sample,
  input  logic [HEIGHT_BITS:0] s1_ahead,
  input  logic [31:0]          threshold_sq,
  output logic                 s1_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stc_pkg::out_beat_t   out_data
);
  import stc_pkg::*;

  localparam int HB   = HEIGHT_BITS;
  localparam int SQW  = 2 * HB;
  localparam int SUMW = SQW + 1;
  localparam int CMPW = (SUMW > 32) ? SUMW : 32;

  logic          v2_r;
  cell_pos_t     pos2_r;
  logic [SQW-1:0] sq1_r;
  logic [SQW-1:0] sq2_r;
  logic          fixed_r;
  cell_class_t   fixed_cls_r;
  logic          out_valid_r;
  out_beat_t     out_data_r;

  logic          en2;
  logic          en_out;
  logic signed [HB:0] d1;
  logic signed [HB:0] d2;
  logic [HB-1:0] a1;
  logic [HB-1:0] a2;
  logic          fixed;
  cell_class_t   fixed_cls;
  logic [SUMW-1:0] sum;
  cell_class_t   cls;

  assign en_out  = !out_valid_r || !out_stall;
  assign en2     = !v2_r || en_out;
  assign s1_take = en2;

  assign d1 = $signed({s1_cell[HB-1], s1_cell[HB-1:0]})
            - $signed({s1_sample[HB-1], s1_sample[HB-1:0]});
  assign d2 = $signed({s1_cell[HB-1], s1_cell[HB-1:0]})
            - $signed({s1_ahead[HB-1], s1_ahead[HB-1:0]});
  assign a1 = d1[HB] ? HB'(-d1) : HB'(d1);
  assign a2 = d2[HB] ? HB'(-d2) : HB'(d2);

  always_comb begin
    if (s1_cell[HB]) begin
      fixed     = 1'b1;
      fixed_cls = CLASS_UNKNOWN;
    end else if (s1_sample[HB] || s1_ahead[HB]) begin
      fixed     = 1'b1;
      fixed_cls = CLASS_FREE;
    end else begin
      fixed     = 1'b0;
      fixed_cls = CLASS_FREE;
    end
  end

  assign sum = SUMW'(sq1_r) + SUMW'(sq2_r);

  always_comb begin
    if (fixed_r) begin
      cls = fixed_cls_r;
    end else if (CMPW'(sum) > CMPW'(threshold_sq)) begin
      cls = CLASS_OCCUPIED;
    end else begin
      cls = CLASS_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= s1_valid;
      end
      if (en_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      pos2_r      <= s1_pos;
      sq1_r       <= SQW'(a1) * SQW'(a1);
      sq2_r       <= SQW'(a2) * SQW'(a2);
      fixed_r     <= fixed;
      fixed_cls_r <= fixed_cls;
    end
    if (en_out && v2_r) begin
      out_data_r.cell_row    <= pos2_r.cell_row;
      out_data_r.cell_column <= pos2_r.cell_column;
      out_data_r.cell_class  <= cls;
      out_data_r.frame_last  <= pos2_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/slope_traversability_classifier.sv
// An accepted sample's result passes through registers v1_r, v2_r and out_valid_r in turn.
// Throughput: a sample beat per cycle unless stalled; one row store read and write per beat.
// Border samples produce no result beat and occupy no pipeline slot.
// Reset (synchronous, rst_n low) clears the grid counters, pipeline valids and loads
// the register defaults; the row store is not cleared and holds stale data until written.
module slope_traversability_classifier #(
  parameter int MAX_COLUMNS = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  stc_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output stc_pkg::out_beat_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import stc_pkg::*;

  localparam int CXW = $clog2(MAX_COLUMNS) + 1;

  logic [31:0]          threshold_sq;
  logic [CXW-1:0]       cols;
  logic [SIZE_W-1:0]    rows;
  logic                 s1_take;
  logic                 s1_valid;
  cell_pos_t            s1_pos;
  logic [HEIGHT_BITS:0] s1_cell;
  logic [HEIGHT_BITS:0] s1_sample;
  logic [HEIGHT_BITS:0] s1_ahead;

  stc_cfg #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_sq(threshold_sq),
    .cols        (cols),
    .rows        (rows)
  );

  stc_row_buffer #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_row_buffer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cols     (cols),
    .rows     (rows),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_cell  (s1_cell),
    .s1_sample(s1_sample),
    .s1_ahead (s1_ahead)
  );

  stc_grade #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_grade (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_pos      (s1_pos),
    .s1_cell     (s1_cell),
    .s1_sample   (s1_sample),
    .s1_ahead    (s1_ahead),
    .threshold_sq(threshold_sq),
    .s1_take     (s1_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: sim/tb.sv
module tb;
  import stc_pkg::*;

  localparam int MAX_COLS     = 1024;
  localparam int RANDOM_BEATS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct packed {
    in_beat_t    beat;
    logic        typed;
    cell_class_t cls;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  slope_traversability_classifier u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies and slope predictor state
  logic [15:0] thr_reg;
  logic [SIZE_W-1:0] cols_reg;
  logic [SIZE_W-1:0] rows_reg;
  logic [16:0] line_buf [0:MAX_COLS-1];
  logic [16:0] above_prev;
  int grid_row;
  int grid_col;

  out_beat_t expected_cells [$];
  int mismatches = 0;
  int beats_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  function automatic int eff_size(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic classify_sample(input in_beat_t b, output bit hit, output out_beat_t res);
    int cols;
    int rows;
    int c;
    int r;
    logic [16:0] smp;
    logic [16:0] ahead;
    logic [16:0] center;
    longint d1;
    longint d2;
    longint th;
    cols = eff_size(int'(cols_reg), MAX_COLS);
    rows = eff_size(int'(rows_reg), MAX_ROWS);
    smp = {b.unknown, b.elevation};
    if (b.frame_start) begin
      grid_row = 0;
      grid_col = 0;
    end
    c = grid_col;
    r = grid_row;
    ahead = (c + 1 < MAX_COLS) ? line_buf[c + 1] : '0;
    center = above_prev;
    hit = 1'b0;
    res = '0;
    if (r >= 2 && r <= rows - 1 && c >= 1 && c <= cols - 2) begin
      if (center[16]) begin
        res.cell_class = CLASS_UNKNOWN;
      end else if (smp[16] || ahead[16]) begin
        res.cell_class = CLASS_FREE;
      end else begin
        d1 = longint'($signed(center[15:0])) - longint'($signed(smp[15:0]));
        d2 = longint'($signed(center[15:0])) - longint'($signed(ahead[15:0]));
        if (d1 < 0) d1 = -d1;
        if (d2 < 0) d2 = -d2;
        th = longint'(thr_reg);
        res.cell_class = (d1 * d1 + d2 * d2 > th * th) ? CLASS_OCCUPIED : CLASS_FREE;
      end
      res.cell_row = 10'(r - 1);
      res.cell_column = 10'(c);
      res.frame_last = (r - 1 == rows - 2 && c == cols - 2);
      hit = 1'b1;
    end
    above_prev = ahead;
    if (c < MAX_COLS) line_buf[c] = smp;
    if (c + 1 >= cols) begin
      grid_col = 0;
      grid_row = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      grid_col = c + 1;
    end
  endtask

  function automatic int pick_pause();
    int n;
    n = $urandom_range(0, 99);
    if (calm || n < 55) return 0;
    if (n < 88) return $urandom_range(1, 3);
    if (n < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic probe_t probe(input int elev, input bit unk, input bit fs,
                                   input bit typed, input cell_class_t cls);
    probe_t p;
    p.beat.elevation = 16'(elev);
    p.beat.unknown = unk;
    p.beat.frame_start = fs;
    p.typed = typed;
    p.cls = cls;
    return p;
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input cell_class_t cls);
    int pause;
    bit hit;
    out_beat_t cell_res;
    pause = pick_pause();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    classify_sample(b, hit, cell_res);
    if (hit) begin
      if (typed) cell_res.cell_class = cls;
      expected_cells.push_back(cell_res);
    end
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic cfg_access(input reg_index_t idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_register(input reg_index_t idx);
    logic [31:0] got;
    logic [31:0] want;
    cfg_access(idx, 1'b0, '0, got);
    case (idx)
      REG_THRESHOLD: want = {16'd0, thr_reg};
      REG_COLUMNS:   want = {21'd0, cols_reg};
      default:       want = {21'd0, rows_reg};
    endcase
    if (got !== want) begin
      mismatches++;
      $display("%0t: register %0d expected %h, got %h", $time, idx, want, got);
    end
  endtask

  task automatic cfg_set(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] unused_rd;
    cfg_access(idx, 1'b1, value, unused_rd);
    case (idx)
      REG_THRESHOLD: thr_reg = value[15:0];
      REG_COLUMNS:   cols_reg = value[SIZE_W-1:0];
      default:       rows_reg = value[SIZE_W-1:0];
    endcase
    check_register(idx);
  endtask

  task automatic run_phase(input logic [31:0] thr_v, input logic [31:0] cols_v,
                           input logic [31:0] rows_v, input int frames, input bit squeeze);
    int old_cols;
    int cols;
    int rows;
    int area;
    int total;
    int base;
    int spread;
    bit restart;
    bit wide;
    bit noisy;
    in_beat_t b;
    old_cols = eff_size(int'(cols_reg), MAX_COLS);
    settle(6);
    cfg_set(REG_THRESHOLD, thr_v);
    cfg_set(REG_COLUMNS, cols_v);
    cfg_set(REG_ROWS, rows_v);
    cols = eff_size(int'(cols_reg), MAX_COLS);
    rows = eff_size(int'(rows_reg), MAX_ROWS);
    // a wider row would read row store entries not written in this frame
    restart = (cols > old_cols) || ($urandom_range(0, 3) != 0);
    calm = ($urandom_range(0, 3) == 0);
    wide = ($urandom_range(0, 4) == 0);
    noisy = ($urandom_range(0, 3) == 0);
    base = $urandom_range(0, 65535) - 32768;
    spread = int'(thr_reg) + int'(thr_reg) / 4 + 2;
    area = rows * cols;
    total = frames * area + $urandom_range(0, 2 * cols);
    if (squeeze) hold_request = 1'b1;
    for (int i = 0; i < total; i++) begin
      if (i % area == 0 && i < frames * area)
        b.frame_start = (i == 0) ? restart : ($urandom_range(0, 3) != 0);
      else
        b.frame_start = noisy && ($urandom_range(0, 39) == 0);
      b.unknown = ($urandom_range(0, 11) == 0);
      if (wide)
        b.elevation = 16'($urandom);
      else if ($urandom_range(0, 9) == 0)
        b.elevation = 16'(base);
      else
        b.elevation = 16'(base + $urandom_range(0, 2 * spread) - spread);
      send_beat(b, 1'b0, CLASS_FREE);
    end
  endtask

  task automatic check_field(input string tag, input logic [9:0] got, input logic [9:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin : cell_check
    out_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        $display("%0t: beat %h arrived, expected none", $time, out_data);
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_row", out_data.cell_row, want.cell_row);
        check_field("cell_column", out_data.cell_column, want.cell_column);
        check_field("cell_class", 10'(out_data.cell_class), 10'(want.cell_class));
        check_field("frame_last", 10'(out_data.frame_last), 10'(want.frame_last));
      end
    end
  end

  initial begin : drain_side
    int run;
    int n;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 65) begin
          out_stall <= 1'b0;
          run = $urandom_range(0, 7);
        end else if (n < 95) begin
          out_stall <= 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    probe_t probes [24];
    logic [31:0] thr_v;
    logic [31:0] cols_v;
    logic [31:0] rows_v;
    int frames;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    thr_reg = THRESHOLD_RESET;
    cols_reg = SIZE_RESET;
    rows_reg = SIZE_RESET;
    foreach (line_buf[k]) line_buf[k] = '0;
    above_prev = '0;
    grid_row = 0;
    grid_col = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_register(REG_THRESHOLD);
    check_register(REG_COLUMNS);
    check_register(REG_ROWS);

    // three-column strip, threshold at reset value; the result for row r-1 lands on row r
    cfg_set(REG_COLUMNS, 32'd0);
    cfg_set(REG_ROWS, 32'd2047);
    probes = '{
      probe(0, 0, 1, 0, CLASS_FREE), probe(0, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE), probe(0, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE), probe(100, 0, 0, 1, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE), probe(101, 0, 0, 1, CLASS_OCCUPIED),
      probe(-32768, 0, 0, 0, CLASS_FREE),
      probe(0, 0, 0, 0, CLASS_FREE), probe(32767, 1, 0, 1, CLASS_FREE),
      probe(0, 1, 0, 0, CLASS_FREE),
      probe(-32768, 1, 0, 0, CLASS_FREE), probe(-32768, 0, 0, 1, CLASS_UNKNOWN),
      probe(32767, 0, 0, 0, CLASS_FREE),
      probe(32767, 0, 0, 0, CLASS_FREE), probe(32767, 0, 0, 1, CLASS_OCCUPIED),
      probe(-1, 1, 0, 0, CLASS_FREE),
      probe(-1, 0, 0, 0, CLASS_FREE), probe(32767, 0, 0, 1, CLASS_FREE),
      probe(-1, 0, 0, 0, CLASS_FREE)
    };
    foreach (probes[i]) send_beat(probes[i].beat, probes[i].typed, probes[i].cls);

    while (beats_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 5))
        0:       thr_v = 32'd0;
        1:       thr_v = 32'd65535;
        2:       thr_v = $urandom_range(0, 65535);
        default: thr_v = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 9))
        8:       cols_v = $urandom_range(0, 2);
        9:       cols_v = $urandom_range(11, 40);
        default: cols_v = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 9))
        8:       rows_v = $urandom_range(0, 2);
        9:       rows_v = $urandom_range(9, 20);
        default: rows_v = $urandom_range(3, 8);
      endcase
      frames = (eff_size(cols_v, MAX_COLS) * eff_size(rows_v, MAX_ROWS) > 100) ?
               1 : $urandom_range(1, 3);
      run_phase(thr_v, cols_v, rows_v, frames, 1'b0);
    end

    // hold off the receiver across a tall narrow frame
    run_phase(32'd65535, 32'd2, 32'd60, 1, 1'b1);

    settle(20);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: slope_traversability_classifier.f
hdl/stc_pkg.sv
hdl/stc_cfg.sv
hdl/stc_row_buffer.sv
hdl/stc_grade.sv
hdl/slope_traversability_classifier.sv
sim/tb.sv
